// ----- rtl/core/ppa_pkg.sv -----
package ppa_pkg;

    // Pool geometry
    localparam int POOL_PAGES = 1024;
    localparam int PAGE_SHIFT = 12;

    // Fixed field widths
    localparam int ADDR_W    = 64;
    localparam int COUNT_W   = 11;
    localparam int RSV_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Bitmap organization: one memory word holds the used bits of WORD_W pages
    localparam int WORD_W    = 32;
    localparam int WORD_BITS = $clog2(WORD_W);
    localparam int NUM_WORDS = (POOL_PAGES + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IDX_W     = WADDR_W + WORD_BITS;
    localparam int TAIL_BITS = POOL_PAGES - (NUM_WORDS - 1) * WORD_W;

    // Run lengths: a free run plus one more word of carry
    localparam int RUN_W = $clog2(POOL_PAGES + WORD_W + 1);
    localparam int LEN_W = WORD_BITS + 1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_RUN   = 2'd1,
        ST_BAD_FREE = 2'd2,
        ST_ZERO     = 2'd3
    } t_status;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE = 1'd0,
        CFG_RESERVED  = 1'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FREE_RANGE,
        S_FREE_CHK,
        S_CLEAR,
        S_RESP
    } t_state;

    // One bitmap access per cycle: a read and an optional write
    typedef struct packed {
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
        logic [WADDR_W-1:0] rd_addr;
    } t_mem_req;

    // Outcome of evaluating one bitmap word during the free-run scan
    typedef struct packed {
        logic                 hit;
        logic [WORD_BITS-1:0] hit_bit;
        logic [RUN_W-1:0]     carry;
    } t_scan_res;

endpackage

// ----- rtl/core/ppa_bitmap.sv -----
module ppa_bitmap (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ppa_pkg::t_mem_req               i_req,
    output logic [ppa_pkg::WORD_W-1:0]      o_rd_data
);

    logic [ppa_pkg::WORD_W-1:0]    r_mem [ppa_pkg::NUM_WORDS];
    logic [ppa_pkg::NUM_WORDS-1:0] r_valid;
    logic [ppa_pkg::WORD_W-1:0]    r_rd_data;

    // Write the word and register the read; a word never written reads as all free
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_valid[i_req.rd_addr] ? r_mem[i_req.rd_addr] : '0;
    end

    // Track which words hold written data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/ppa_run_eval.sv -----
module ppa_run_eval (
    input  logic [ppa_pkg::WORD_W-1:0] i_used,
    input  logic [ppa_pkg::RUN_W-1:0]  i_carry,
    input  logic [ppa_pkg::RUN_W-1:0]  i_need,
    output ppa_pkg::t_scan_res         o_res
);

    localparam int W     = ppa_pkg::WORD_W;
    localparam int STEPS = ppa_pkg::WORD_BITS;
    localparam int LW    = ppa_pkg::LEN_W;
    localparam int RW    = ppa_pkg::RUN_W;

    // len[s][j]: free pages ending at bit j, looking back at most 2^s bits
    logic [LW-1:0] len [STEPS+1][W];
    logic [RW-1:0] run [W];
    logic [W-1:0]  hit;

    genvar s, j;

    for (j = 0; j < W; j++) begin : g_init
        assign len[0][j] = i_used[j] ? '0 : LW'(1);
    end

    // Double the look-back window each step
    for (s = 0; s < STEPS; s++) begin : g_step
        for (j = 0; j < W; j++) begin : g_bit
            if (j >= (1 << s)) begin : g_join
                assign len[s+1][j] = (len[s][j] == LW'(1 << s))
                                   ? LW'(1 << s) + len[s][j-(1<<s)]
                                   : len[s][j];
            end else begin : g_pass
                assign len[s+1][j] = len[s][j];
            end
        end
    end

    // Extend runs that reach bit 0 with the run carried from lower words
    for (j = 0; j < W; j++) begin : g_run
        assign run[j] = (len[STEPS][j] == LW'(j + 1)) ? i_carry + RW'(j + 1)
                                                      : RW'(len[STEPS][j]);
        assign hit[j] = (run[j] >= i_need);
    end

    // Pick the lowest bit that completes a run
    always_comb begin
        o_res.hit_bit = '0;
        for (int k = W - 1; k >= 0; k--) begin
            if (hit[k]) begin
                o_res.hit_bit = ppa_pkg::WORD_BITS'(k);
            end
        end
        o_res.hit   = |hit;
        o_res.carry = (len[STEPS][W-1] == LW'(W)) ? i_carry + RW'(W)
                                                  : RW'(len[STEPS][W-1]);
    end

endmodule

// ----- rtl/core/bitmap_page_pool_allocator.sv -----
// First-fit page pool allocator. Each request returns one result. An allocate
// scans the used-page bitmap one 32-page word per cycle, starting at the word
// that holds the first non-reserved page, and stops at the word that completes
// the lowest free run of page_count pages; it then sets the run's bits one word
// per cycle. A free checks the range word by word and fails on any page that is
// not in use, then clears the range, one word per cycle per pass. The bitmap
// sits in a memory with one read and one write port and a registered read. A
// zero-count request or an allocate rejected up front goes straight to the
// response, as does a free that fails the range check. The bitmap is all free
// after reset with no clearing pass. The next request is taken while a
// finished result still waits at the output register.
module bitmap_page_pool_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_func,
    input  logic [ppa_pkg::COUNT_W-1:0]       i_page_count,
    input  logic [ppa_pkg::ADDR_W-1:0]        i_free_addr,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ppa_pkg::ADDR_W-1:0]        o_alloc_addr,
    output logic [1:0]                        o_status,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ppa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ppa_pkg::ADDR_W-1:0]        i_cfg_data
);

    localparam int W       = ppa_pkg::WORD_W;
    localparam int WB      = ppa_pkg::WORD_BITS;
    localparam int WA      = ppa_pkg::WADDR_W;
    localparam int IW      = ppa_pkg::IDX_W;
    localparam int RW      = ppa_pkg::RUN_W;
    localparam int AW      = ppa_pkg::ADDR_W;
    localparam int FI_W    = ppa_pkg::ADDR_W - ppa_pkg::PAGE_SHIFT;
    localparam logic [W-1:0] TAIL_USED = ~({W{1'b1}} >> (W - ppa_pkg::TAIL_BITS));
    localparam logic [WA-1:0] LAST_WORD = WA'(ppa_pkg::NUM_WORDS - 1);

    // Pages of word k that fall within first..last
    function automatic logic [W-1:0] range_mask(input logic [WA-1:0] k,
                                                input logic [IW-1:0] first,
                                                input logic [IW-1:0] last);
        logic [W-1:0] lo_part;
        logic [W-1:0] hi_part;
        lo_part = (k == first[IW-1:WB]) ? ({W{1'b1}} << first[WB-1:0]) : {W{1'b1}};
        hi_part = (k == last[IW-1:WB])
                ? ({W{1'b1}} >> (WB'(W - 1) - last[WB-1:0])) : {W{1'b1}};
        return lo_part & hi_part;
    endfunction

    // Control registers
    ppa_pkg::t_state                 r_state, n_state;
    logic                            r_pend, n_pend;
    logic                            r_out_valid;
    logic [AW-1:0]                   r_pool_base;
    logic [ppa_pkg::RSV_W-1:0]       r_reserved;

    // Payload registers
    logic [ppa_pkg::COUNT_W-1:0]     r_count;
    logic [AW-1:0]                   r_diff;
    logic [WA-1:0]                   r_word, n_word;
    logic [WA-1:0]                   r_ev_word;
    logic [RW-1:0]                   r_carry;
    logic [IW-1:0]                   r_first;
    logic [IW-1:0]                   r_last;
    logic [AW-1:0]                   r_res_addr;
    ppa_pkg::t_status                r_res_status;
    logic [AW-1:0]                   r_out_addr;
    ppa_pkg::t_status                r_out_status;

    // Datapath signals
    ppa_pkg::t_mem_req               mem_req;
    logic [W-1:0]                    rd_data;
    ppa_pkg::t_scan_res              scan_res;
    logic [W-1:0]                    used_eff;
    logic [W-1:0]                    wmask;
    logic [RW-1:0]                   lo_limit;
    logic [IW-1:0]                   lo_idx;
    logic [WA-1:0]                   lo_w;
    logic [IW-1:0]                   hit_end;
    logic [IW-1:0]                   hit_first;
    logic [FI_W-1:0]                 fidx;
    logic [31:0]                     fidx_lo;
    logic [31:0]                     fend;
    logic [IW-1:0]                   free_first;
    logic [IW-1:0]                   free_last;
    logic                            free_bad;
    logic                            in_accept;
    logic                            out_free;
    logic                            zero_cnt;
    logic                            alloc_reject;
    logic                            scan_hit;
    logic                            scan_miss;
    logic                            sweep_last;
    logic                            chk_bad;

    ppa_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    ppa_run_eval u_run_eval (
        .i_used  (used_eff),
        .i_carry (r_carry),
        .i_need  (RW'(r_count)),
        .o_res   (scan_res)
    );

    // Reserved limit, clamped to the pool
    assign lo_limit = (32'(r_reserved) > 32'(ppa_pkg::POOL_PAGES))
                    ? RW'(ppa_pkg::POOL_PAGES) : RW'(r_reserved);
    assign lo_idx   = IW'(lo_limit);
    assign lo_w     = lo_idx[IW-1:WB];

    assign in_accept    = i_in_valid && (r_state == ppa_pkg::S_IDLE);
    assign out_free     = !r_out_valid || !i_out_stall;
    assign zero_cnt     = (i_page_count == '0);
    assign alloc_reject = (32'(i_page_count) > 32'(ppa_pkg::POOL_PAGES))
                       || (32'(lo_limit) == 32'(ppa_pkg::POOL_PAGES));

    // Scan: treat reserved pages and pages past the pool as used
    always_comb begin
        used_eff = rd_data;
        if (r_ev_word == lo_w) begin
            used_eff = used_eff | ~({W{1'b1}} << lo_idx[WB-1:0]);
        end
        if (r_ev_word == LAST_WORD) begin
            used_eff = used_eff | TAIL_USED;
        end
    end

    assign scan_hit  = r_pend && scan_res.hit;
    assign scan_miss = r_pend && !scan_res.hit && (r_ev_word == LAST_WORD);
    assign hit_end   = {r_ev_word, scan_res.hit_bit};
    assign hit_first = hit_end + IW'(1) - IW'(r_count);

    // Sweep over the words of first..last
    assign wmask      = range_mask(r_ev_word, r_first, r_last);
    assign sweep_last = r_pend && (r_ev_word == r_last[IW-1:WB]);
    assign chk_bad    = r_pend && ((wmask & ~rd_data) != '0);

    // Free range checks on the page index
    assign fidx       = r_diff[AW-1:ppa_pkg::PAGE_SHIFT];
    assign fidx_lo    = 32'(fidx[RW-1:0]);
    assign fend       = fidx_lo + 32'(r_count);
    assign free_bad   = (fidx > FI_W'(ppa_pkg::POOL_PAGES))
                     || (fend > 32'(ppa_pkg::POOL_PAGES))
                     || (fidx_lo < 32'(lo_limit));
    assign free_first = IW'(fidx_lo);
    assign free_last  = IW'(fend - 32'd1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ppa_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (zero_cnt) begin
                        n_state = ppa_pkg::S_RESP;
                    end else if (i_func == ppa_pkg::FUNC_FREE) begin
                        n_state = ppa_pkg::S_FREE_RANGE;
                    end else if (alloc_reject) begin
                        n_state = ppa_pkg::S_RESP;
                    end else begin
                        n_state = ppa_pkg::S_SCAN;
                    end
                end
            end
            ppa_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_state = ppa_pkg::S_MARK;
                end else if (scan_miss) begin
                    n_state = ppa_pkg::S_RESP;
                end
            end
            ppa_pkg::S_MARK: begin
                if (sweep_last) begin
                    n_state = ppa_pkg::S_RESP;
                end
            end
            ppa_pkg::S_FREE_RANGE: begin
                n_state = free_bad ? ppa_pkg::S_RESP : ppa_pkg::S_FREE_CHK;
            end
            ppa_pkg::S_FREE_CHK: begin
                if (chk_bad) begin
                    n_state = ppa_pkg::S_RESP;
                end else if (sweep_last) begin
                    n_state = ppa_pkg::S_CLEAR;
                end
            end
            ppa_pkg::S_CLEAR: begin
                if (sweep_last) begin
                    n_state = ppa_pkg::S_RESP;
                end
            end
            ppa_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = ppa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppa_pkg::S_IDLE;
            end
        endcase
        // Read data is pending only while a sweep keeps going
        n_pend = (n_state == r_state) && (r_state inside {ppa_pkg::S_SCAN,
                 ppa_pkg::S_MARK, ppa_pkg::S_FREE_CHK, ppa_pkg::S_CLEAR});
    end

    // Next read address: jump to the start of a new sweep or advance one word
    always_comb begin
        n_word = r_word + WA'(1);
        case (r_state)
            ppa_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_word = lo_w;
                end
            end
            ppa_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_word = hit_first[IW-1:WB];
                end
            end
            ppa_pkg::S_FREE_RANGE: begin
                n_word = free_first[IW-1:WB];
            end
            ppa_pkg::S_FREE_CHK: begin
                if (!chk_bad && sweep_last) begin
                    n_word = r_first[IW-1:WB];
                end
            end
            default: begin
                n_word = r_word + WA'(1);
            end
        endcase
    end

    // Outputs: stall and bitmap access
    always_comb begin
        o_in_stall      = (r_state != ppa_pkg::S_IDLE);
        mem_req.rd_addr = r_word;
        mem_req.wr_addr = r_ev_word;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_data = rd_data | wmask;
        case (r_state)
            ppa_pkg::S_MARK: begin
                mem_req.wr_en = r_pend;
            end
            ppa_pkg::S_CLEAR: begin
                mem_req.wr_en   = r_pend;
                mem_req.wr_data = rd_data & ~wmask;
            end
            default: begin
                mem_req.wr_en = 1'b0;
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppa_pkg::S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pool_base <= '0;
            r_reserved  <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (r_state == ppa_pkg::S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ppa_pkg::CFG_POOL_BASE: r_pool_base <= i_cfg_data;
                    ppa_pkg::CFG_RESERVED:  r_reserved  <= i_cfg_data[ppa_pkg::RSV_W-1:0];
                    default: begin
                        r_reserved <= r_reserved;
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_ev_word <= r_word;
        case (r_state)
            ppa_pkg::S_IDLE: begin
                if (in_accept) begin
                    r_count    <= i_page_count;
                    r_diff     <= i_free_addr - r_pool_base;
                    r_carry    <= '0;
                    r_res_addr <= '0;
                    if (zero_cnt) begin
                        r_res_status <= ppa_pkg::ST_ZERO;
                    end else if (i_func == ppa_pkg::FUNC_ALLOC && alloc_reject) begin
                        r_res_status <= ppa_pkg::ST_NO_RUN;
                    end else begin
                        r_res_status <= ppa_pkg::ST_OK;
                    end
                end
            end
            ppa_pkg::S_SCAN: begin
                if (r_pend) begin
                    r_carry <= scan_res.carry;
                end
                if (scan_hit) begin
                    r_first <= hit_first;
                    r_last  <= hit_end;
                end else if (scan_miss) begin
                    r_res_status <= ppa_pkg::ST_NO_RUN;
                end
            end
            ppa_pkg::S_MARK: begin
                if (sweep_last) begin
                    r_res_addr <= r_pool_base + (AW'(r_first) << ppa_pkg::PAGE_SHIFT);
                end
            end
            ppa_pkg::S_FREE_RANGE: begin
                r_first <= free_first;
                r_last  <= free_last;
                if (free_bad) begin
                    r_res_status <= ppa_pkg::ST_BAD_FREE;
                end
            end
            ppa_pkg::S_FREE_CHK: begin
                if (chk_bad) begin
                    r_res_status <= ppa_pkg::ST_BAD_FREE;
                end
            end
            ppa_pkg::S_RESP: begin
                if (out_free) begin
                    r_out_addr   <= r_res_addr;
                    r_out_status <= r_res_status;
                end
            end
            default: begin
                r_carry <= r_carry;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_alloc_addr = r_out_addr;
    assign o_status     = r_out_status;
    assign o_cfg_ready  = 1'b1;

endmodule
